// ===== rtl/cbcn_pkg.sv =====
package cbcn_pkg;

    localparam int COORD_BITS       = 16;
    localparam int RADIUS_BITS      = 12;
    localparam int NORMAL_BITS      = 16;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int EXT_BITS  = COORD_BITS + 2;
    localparam int SQ_BITS   = 2 * RADIUS_BITS;
    localparam int D2_BITS   = SQ_BITS + 1;
    localparam int ACC_BITS  = SQ_BITS + 2 * NORMAL_FRAC_BITS + 8;
    localparam int Q_BITS    = NORMAL_FRAC_BITS + 1;
    localparam int STEPS     = NORMAL_FRAC_BITS + 1;

    localparam logic [1:0] FACE_LEFT   = 2'd0;
    localparam logic [1:0] FACE_RIGHT  = 2'd1;
    localparam logic [1:0] FACE_TOP    = 2'd2;
    localparam logic [1:0] FACE_BOTTOM = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic [RADIUS_BITS-1:0]       radius;
        logic signed [COORD_BITS-1:0] box_x;
        logic signed [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-2:0]        box_width;
        logic [COORD_BITS-2:0]        box_height;
    } item_t;

    typedef struct packed {
        logic                          hit;
        logic signed [NORMAL_BITS-1:0] normal_x;
        logic signed [NORMAL_BITS-1:0] normal_y;
    } result_t;

    // state carried through the normalising steps
    typedef struct packed {
        logic                       hit;
        logic                       enclosed;
        logic                       neg_x;
        logic                       neg_y;
        logic [1:0]                 face;
        logic [D2_BITS-1:0]         d2;
        logic [SQ_BITS-1:0]         sq_x;
        logic [SQ_BITS-1:0]         sq_y;
        logic signed [ACC_BITS-1:0] e_x;
        logic signed [ACC_BITS-1:0] l_x;
        logic signed [ACC_BITS-1:0] e_y;
        logic signed [ACC_BITS-1:0] l_y;
        logic [Q_BITS-1:0]          q_x;
        logic [Q_BITS-1:0]          q_y;
    } nrm_t;

endpackage

// ===== rtl/cbcn_front.sv =====
module cbcn_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_vld,
    input  cbcn_pkg::item_t in_item,
    output logic           out_vld,
    output cbcn_pkg::nrm_t out_st
);
    import cbcn_pkg::*;

    // stage 1: clamp, offsets, face distances
    logic                       v1_reg;
    logic signed [EXT_BITS-1:0] dx_reg, dy_reg;
    logic signed [EXT_BITS-1:0] f_reg [4];
    logic [RADIUS_BITS-1:0]     r1_reg;

    logic signed [EXT_BITS-1:0] cx, cy, bx, by, hx, hy, kx, ky;

    always_comb
    begin
        cx = EXT_BITS'(in_item.center_x);
        cy = EXT_BITS'(in_item.center_y);
        bx = EXT_BITS'(in_item.box_x);
        by = EXT_BITS'(in_item.box_y);
        hx = bx + $signed({3'b000, in_item.box_width});
        hy = by + $signed({3'b000, in_item.box_height});
        kx = (cx < bx) ? bx : ((cx > hx) ? hx : cx);
        ky = (cy < by) ? by : ((cy > hy) ? hy : cy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg   <= cx - kx;
            dy_reg   <= cy - ky;
            f_reg[0] <= cx - bx;
            f_reg[1] <= hx - cx;
            f_reg[2] <= cy - by;
            f_reg[3] <= hy - cy;
            r1_reg   <= in_item.radius;
        end
    end

    // stage 2: magnitudes, squares, nearest face
    logic                   v2_reg, ok_reg, nx_reg, ny_reg;
    logic [SQ_BITS-1:0]     sqx_reg, sqy_reg, r2_reg;
    logic [1:0]             face_reg;

    logic [EXT_BITS-1:0]    ax, ay;
    logic [RADIUS_BITS-1:0] mx, my;
    logic [1:0]             best;
    logic signed [EXT_BITS-1:0] bestv;

    always_comb
    begin
        ax = dx_reg[EXT_BITS-1] ? EXT_BITS'(-dx_reg) : EXT_BITS'(dx_reg);
        ay = dy_reg[EXT_BITS-1] ? EXT_BITS'(-dy_reg) : EXT_BITS'(dy_reg);
        mx = ax[RADIUS_BITS-1:0];
        my = ay[RADIUS_BITS-1:0];
        best  = FACE_LEFT;
        bestv = f_reg[0];
        if (f_reg[1] < bestv)
        begin
            best  = FACE_RIGHT;
            bestv = f_reg[1];
        end
        if (f_reg[2] < bestv)
        begin
            best  = FACE_TOP;
            bestv = f_reg[2];
        end
        if (f_reg[3] < bestv)
        begin
            best = FACE_BOTTOM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_reg   <= (ax <= EXT_BITS'(r1_reg)) && (ay <= EXT_BITS'(r1_reg));
            nx_reg   <= dx_reg[EXT_BITS-1];
            ny_reg   <= dy_reg[EXT_BITS-1];
            sqx_reg  <= mx * mx;
            sqy_reg  <= my * my;
            r2_reg   <= r1_reg * r1_reg;
            face_reg <= best;
        end
    end

    // stage 3: squared distance, hit, step seeds
    logic               v3_reg;
    nrm_t               st_reg;
    logic [D2_BITS-1:0] d2;
    logic signed [ACC_BITS-1:0] d2e;

    always_comb
    begin
        d2  = D2_BITS'(sqx_reg) + D2_BITS'(sqy_reg);
        d2e = $signed(ACC_BITS'(d2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg.hit      <= ok_reg && (d2 <= D2_BITS'(r2_reg));
            st_reg.enclosed <= (d2 == '0);
            st_reg.neg_x    <= nx_reg;
            st_reg.neg_y    <= ny_reg;
            st_reg.face     <= face_reg;
            st_reg.d2       <= d2;
            st_reg.sq_x     <= sqx_reg;
            st_reg.sq_y     <= sqy_reg;
            st_reg.e_x      <= d2e;
            st_reg.l_x      <= -d2e;
            st_reg.e_y      <= d2e;
            st_reg.l_y      <= -d2e;
            st_reg.q_x      <= '0;
            st_reg.q_y      <= '0;
        end
    end

    assign out_vld = v3_reg;
    assign out_st  = st_reg;

endmodule

// ===== rtl/cbcn_nstep.sv =====
module cbcn_nstep #(
    parameter int BIT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_vld,
    input  cbcn_pkg::nrm_t in_st,
    output logic           out_vld,
    output cbcn_pkg::nrm_t out_st
);
    import cbcn_pkg::*;

    // E = (2q-1)^2 d2, L = (2q-1) d2; trial bit s: E + 4sL + 4s^2 d2 <= mag^2 2^(2F+2)
    logic                       vld_reg;
    nrm_t                       st_reg;
    nrm_t                       nxt;
    logic signed [ACC_BITS-1:0] d2e, tx, ty, rx, ry;
    logic                       full_x, full_y;

    always_comb
    begin
        d2e = $signed(ACC_BITS'(in_st.d2));
        rx  = $signed(ACC_BITS'(in_st.sq_x) << (2 * NORMAL_FRAC_BITS + 2));
        ry  = $signed(ACC_BITS'(in_st.sq_y) << (2 * NORMAL_FRAC_BITS + 2));
        tx  = in_st.e_x + (in_st.l_x <<< (BIT + 2)) + (d2e <<< (2 * BIT + 2));
        ty  = in_st.e_y + (in_st.l_y <<< (BIT + 2)) + (d2e <<< (2 * BIT + 2));
        full_x = (BIT < NORMAL_FRAC_BITS) && in_st.q_x[NORMAL_FRAC_BITS];
        full_y = (BIT < NORMAL_FRAC_BITS) && in_st.q_y[NORMAL_FRAC_BITS];
        nxt = in_st;
        if (!full_x && (tx <= rx))
        begin
            nxt.e_x      = tx;
            nxt.l_x      = in_st.l_x + (d2e <<< (BIT + 1));
            nxt.q_x[BIT] = 1'b1;
        end
        if (!full_y && (ty <= ry))
        begin
            nxt.e_y      = ty;
            nxt.l_y      = in_st.l_y + (d2e <<< (BIT + 1));
            nxt.q_y[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= nxt;
        end
    end

    assign out_vld = vld_reg;
    assign out_st  = st_reg;

endmodule

// ===== rtl/circle_box_collision_normal_core.sv =====
// Circle against axis-aligned box contact test with unit contact normal.
// Fully pipelined: one circle/box pair may be transferred every cycle and
// each result passes through three front stages for clamp, squares and hit
// test, one stage per normal bit for the 15-bit rounded normalisation and one
// output stage. A stall on the result side freezes the whole pipe and is
// passed back to the item side only while a finished result is held.
module circle_box_collision_normal_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cbcn_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output cbcn_pkg::result_t result
);
    import cbcn_pkg::*;

    logic adv;
    logic vld [STEPS+1];
    nrm_t st  [STEPS+1];

    logic    rv_reg;
    result_t res_reg;
    result_t res_next;
    nrm_t    fin;

    assign adv        = !(rv_reg && result_stall);
    assign item_stall = !adv;

    cbcn_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (item_valid),
        .in_item (item),
        .out_vld (vld[0]),
        .out_st  (st[0])
    );

    for (genvar g = 0; g < STEPS; g++)
    begin : g_step
        cbcn_nstep #(
            .BIT(NORMAL_FRAC_BITS - g)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_vld  (vld[g]),
            .in_st   (st[g]),
            .out_vld (vld[g+1]),
            .out_st  (st[g+1])
        );
    end

    localparam logic signed [NORMAL_BITS-1:0] ONE = NORMAL_BITS'(1 << NORMAL_FRAC_BITS);

    always_comb
    begin
        fin = st[STEPS];
        res_next.hit      = fin.hit;
        res_next.normal_x = '0;
        res_next.normal_y = '0;
        if (fin.hit)
        begin
            if (fin.enclosed)
            begin
                unique case (fin.face)
                    FACE_LEFT:   res_next.normal_x = -ONE;
                    FACE_RIGHT:  res_next.normal_x = ONE;
                    FACE_TOP:    res_next.normal_y = -ONE;
                    default:     res_next.normal_y = ONE;
                endcase
            end
            else
            begin
                res_next.normal_x = fin.neg_x ? -NORMAL_BITS'(fin.q_x) : NORMAL_BITS'(fin.q_x);
                res_next.normal_y = fin.neg_y ? -NORMAL_BITS'(fin.q_y) : NORMAL_BITS'(fin.q_y);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else if (adv)
        begin
            rv_reg <= vld[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/cbcn_checker.sv =====
module cbcn_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input cbcn_pkg::result_t result
);
    import cbcn_pkg::*;

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.hit) |-> (result.normal_x == '0 && result.normal_y == '0))
        else $error("normal not zero without hit");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit) |-> (result.normal_x != '0 || result.normal_y != '0))
        else $error("zero normal on hit");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item side stalled without held result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

bind circle_box_collision_normal_core cbcn_checker u_cbcn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
